FILE: hdl/circle_segment_collide_reflect_core_defines.svh
// Assertion macros shared by the RTL of the circle/segment core.
`ifndef CIRCLE_SEGMENT_COLLIDE_REFLECT_CORE_DEFINES_SVH
`define CIRCLE_SEGMENT_COLLIDE_REFLECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csc assertion failed");
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csc assertion failed");
`else
`define CSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/csc_pkg.sv
package csc_pkg;

    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int TICK_FRAC = 8;
    localparam int TS_W      = 16;
    localparam int RAD_W     = 8;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MUL_W     = DIFF_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int DIV_W     = ACC_W;
    localparam int MAG_W     = DIFF_W;
    localparam int QUO_W     = COORD_W + 3;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEST    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REFLECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
    } t_mul_ctl;

    typedef struct packed {
        logic start;
        logic pre;
        logic reuse;
    } t_div_cmd;

endpackage

FILE: hdl/csc_cfg_if.sv
interface csc_cfg_if
    import csc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/csc_in_if.sv
interface csc_in_if
    import csc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [TS_W-1:0]  timestep;
    t_coord           seg_a_x;
    t_coord           seg_a_y;
    t_coord           seg_b_x;
    t_coord           seg_b_y;
    logic [RAD_W-1:0] pad_pixels;
    logic             check_direction;
    t_coord           box_centre_x;
    t_coord           box_centre_y;

    modport source (output valid, output req_type, output timestep, output seg_a_x,
                    output seg_a_y, output seg_b_x, output seg_b_y, output pad_pixels,
                    output check_direction, output box_centre_x, output box_centre_y,
                    input ready);
    modport sink (input valid, input req_type, input timestep, input seg_a_x,
                  input seg_a_y, input seg_b_x, input seg_b_y, input pad_pixels,
                  input check_direction, input box_centre_x, input box_centre_y,
                  output ready);
endinterface

FILE: hdl/csc_out_if.sv
interface csc_out_if
    import csc_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   collided;
    t_coord pos_x;
    t_coord pos_y;
    t_coord vel_x;
    t_coord vel_y;

    modport source (output valid, output collided, output pos_x, output pos_y,
                    output vel_x, output vel_y, input ready);
    modport sink (input valid, input collided, input pos_x, input pos_y,
                  input vel_x, input vel_y, output ready);
endinterface

FILE: hdl/csc_mul.sv
module csc_mul
    import csc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_ctl                 i_ctl,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    t_mul_ctl                 r_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        prod_ext = $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod});
        n_acc    = (r_ctl.clr ? '0 : r_acc) + (r_ctl.neg ? -prod_ext : prod_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod <= i_a * i_b;
        if (r_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: hdl/csc_div.sv
module csc_div
    import csc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_cmd         i_cmd,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    input  logic [MAG_W-1:0] i_mult,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    // floor(dividend * mult / divisor): optional long division of the dividend first,
    // then the multiplier bits one at a time, MSB first (double, then add remainder)
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [1:0] {D_IDLE, D_PRE, D_MUL} t_dstate;

    t_dstate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_half;
    logic             r_done;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_q0;
    logic [DIV_W-1:0] r_r0;
    logic [DIV_W-1:0] r_c;
    logic [MAG_W-1:0] r_b;
    logic [QUO_W-1:0] r_q;

    logic [DIV_W:0]   trial;
    logic [DIV_W+1:0] diff;
    logic             ge;
    logic [DIV_W-1:0] n_rem;
    logic [QUO_W-1:0] q_trial;
    logic [QUO_W-1:0] n_q;

    always_comb begin
        trial   = '0;
        q_trial = r_q;
        case (r_state)
            D_PRE: begin
                trial = {r_rem, r_num[DIV_W-1]};
            end
            D_MUL: begin
                if (!r_half) begin
                    trial   = {r_rem, 1'b0};
                    q_trial = {r_q[QUO_W-2:0], 1'b0};
                end else if (r_b[MAG_W-1]) begin
                    trial   = {1'b0, r_rem} + {1'b0, r_r0};
                    q_trial = r_q + r_q0[QUO_W-1:0];
                end else begin
                    trial = {1'b0, r_rem};
                end
            end
            default: begin
                trial = '0;
            end
        endcase
        diff  = {1'b0, trial} - {2'b00, r_c};
        ge    = !diff[DIV_W+1];
        n_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_q   = q_trial + QUO_W'(ge);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_half  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_cmd.start) begin
                        r_c    <= i_divisor;
                        r_b    <= i_mult;
                        r_q    <= '0;
                        r_rem  <= '0;
                        r_half <= 1'b0;
                        r_cnt  <= '0;
                        if (i_cmd.pre) begin
                            r_num   <= i_dividend;
                            r_q0    <= '0;
                            r_state <= D_PRE;
                        end else if (i_cmd.reuse) begin
                            r_state <= D_MUL;
                        end else begin
                            r_q0    <= '0;
                            r_r0    <= i_dividend;
                            r_state <= D_MUL;
                        end
                    end
                end
                D_PRE: begin
                    r_rem <= n_rem;
                    r_num <= {r_num[DIV_W-2:0], 1'b0};
                    r_q0  <= {r_q0[DIV_W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W-1)) begin
                        r_r0    <= n_rem;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_rem  <= n_rem;
                    r_q    <= n_q;
                    r_half <= !r_half;
                    if (r_half) begin
                        r_b   <= {r_b[MAG_W-2:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(MAG_W-1)) begin
                            r_done  <= 1'b1;
                            r_state <= D_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: hdl/circle_segment_collide_reflect_core.sv
// Moving circle against line segments in signed Q16.8. One request is in work at a time:
// the core takes a word, runs it on a shared 25x25 multiply-accumulate unit and a shared
// bit-serial multiply-divide unit, and drops the result into an output register, so the
// next word may be taken while the last result waits. A test that finds the nearest point
// inside the segment runs two multiply-divides to place it; one that finds an end does not.
// A test-and-reflect runs the same steps as a test, but stops early for a zero-length
// segment. The direction check adds a dot product first, and a hit adds a long division,
// a multiply-divide on its remainder and a second multiply-divide. Configuration writes
// are taken at any time and should come while idle.
`include "circle_segment_collide_reflect_core_defines.svh"

module circle_segment_collide_reflect_core
    import csc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    csc_cfg_if.sink   i_cfg,
    csc_in_if.sink    i_req,
    csc_out_if.source o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE, S_TICK0, S_TICK1, S_TICK2, S_TICK3,
        S_DIR0, S_DIR1, S_DIR2, S_DIR3,
        S_LEN0, S_LEN1, S_DOT0, S_DOT1, S_DOT2, S_DOT3,
        S_PRJ_X, S_PRJ_XW, S_PRJ_Y, S_PRJ_YW,
        S_DST0, S_DST1, S_DST2, S_DST3, S_DST4,
        S_VS0, S_VS1, S_VS2, S_VS3,
        S_RFL_XW, S_RFL_Y, S_RFL_YW, S_DONE
    } t_state;

    localparam t_mul_ctl MUL_CLR = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
    localparam t_mul_ctl MUL_ADD = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
    localparam t_mul_ctl MUL_SUB = '{en: 1'b1, clr: 1'b0, neg: 1'b1};

    function automatic logic signed [DIFF_W-1:0] ext_d(input t_coord v);
        return $signed({v[COORD_W-1], v});
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_a(input t_coord v);
        return $signed({{(ACC_W-COORD_W){v[COORD_W-1]}}, v});
    endfunction

    function automatic logic [MAG_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
        return MAG_W'(v[DIFF_W-1] ? -v : v);
    endfunction

    function automatic logic signed [ACC_W-1:0] sgn_q(input logic neg,
                                                     input logic [QUO_W-1:0] q);
        logic signed [ACC_W-1:0] t;
        t = $signed({{(ACC_W-QUO_W){1'b0}}, q});
        return neg ? -t : t;
    endfunction

    function automatic t_coord sat_coord(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // configuration
    t_coord           r_start_x, r_start_y, r_start_vx, r_start_vy;
    logic [RAD_W-1:0] r_radius;

    // state and latched request
    t_state           r_state;
    t_coord           r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic [REQ_W-1:0] r_req;
    logic [TS_W-1:0]  r_ts;
    t_coord           r_ax, r_ay, r_bx, r_by, r_box_x, r_box_y;
    logic [RAD_W:0]   r_reach;
    logic signed [ACC_W-1:0] r_len2;
    t_coord           r_near_x, r_near_y;
    logic             r_hit;
    logic             r_vs_neg;

    // output register
    logic             r_out_valid;
    logic             r_out_hit;
    t_coord           r_out_pos_x, r_out_pos_y, r_out_vel_x, r_out_vel_y;

    logic signed [DIFF_W-1:0] dx, dy, sx, sy, wx, wy, ux, uy, ex, ey;
    t_mul_ctl                 mul_ctl;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0]  acc;
    t_div_cmd                 div_cmd;
    logic [DIV_W-1:0]         div_dividend;
    logic [MAG_W-1:0]         div_mult;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quot;
    logic [ACC_W-1:0]         vs_abs;
    logic signed [ACC_W-1:0]  tick_x_sum, tick_y_sum;
    logic signed [ACC_W-1:0]  near_x_sum, near_y_sum;
    logic signed [ACC_W-1:0]  rfl_x_sum, rfl_y_sum;

    always_comb begin
        dx = ext_d(r_ax) - ext_d(r_bx);
        dy = ext_d(r_ay) - ext_d(r_by);
        sx = ext_d(r_bx) - ext_d(r_ax);
        sy = ext_d(r_by) - ext_d(r_ay);
        wx = ext_d(r_pos_x) - ext_d(r_bx);
        wy = ext_d(r_pos_y) - ext_d(r_by);
        ux = ext_d(r_box_x) - ext_d(r_pos_x);
        uy = ext_d(r_box_y) - ext_d(r_pos_y);
        ex = ext_d(r_pos_x) - ext_d(r_near_x);
        ey = ext_d(r_pos_y) - ext_d(r_near_y);

        tick_x_sum = ext_a(r_pos_x) + (acc >>> TICK_FRAC);
        tick_y_sum = ext_a(r_pos_y) + (acc >>> TICK_FRAC);
        near_x_sum = ext_a(r_bx) + sgn_q(dx[DIFF_W-1], div_quot);
        near_y_sum = ext_a(r_by) + sgn_q(dy[DIFF_W-1], div_quot);
        rfl_x_sum  = sgn_q(r_vs_neg ^ sx[DIFF_W-1], div_quot) - ext_a(r_vel_x);
        rfl_y_sum  = sgn_q(r_vs_neg ^ sy[DIFF_W-1], div_quot) - ext_a(r_vel_y);
        vs_abs     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end

    // multiply-accumulate operand select
    always_comb begin
        mul_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_TICK0: begin
                mul_ctl = MUL_CLR;
                mul_a   = $signed({{(MUL_W-TS_W){1'b0}}, r_ts});
                mul_b   = ext_d(r_vel_x);
            end
            S_TICK1: begin
                mul_ctl = MUL_CLR;
                mul_a   = $signed({{(MUL_W-TS_W){1'b0}}, r_ts});
                mul_b   = ext_d(r_vel_y);
            end
            S_DIR0: begin
                mul_ctl = MUL_CLR;
                mul_a   = ux;
                mul_b   = ext_d(r_vel_x);
            end
            S_DIR1: begin
                mul_ctl = MUL_ADD;
                mul_a   = uy;
                mul_b   = ext_d(r_vel_y);
            end
            S_LEN0: begin
                mul_ctl = MUL_CLR;
                mul_a   = dx;
                mul_b   = dx;
            end
            S_LEN1: begin
                mul_ctl = MUL_ADD;
                mul_a   = dy;
                mul_b   = dy;
            end
            S_DOT0: begin
                mul_ctl = MUL_CLR;
                mul_a   = wx;
                mul_b   = dx;
            end
            S_DOT1: begin
                mul_ctl = MUL_ADD;
                mul_a   = wy;
                mul_b   = dy;
            end
            S_DST0: begin
                mul_ctl = MUL_CLR;
                mul_a   = ex;
                mul_b   = ex;
            end
            S_DST1: begin
                mul_ctl = MUL_ADD;
                mul_a   = ey;
                mul_b   = ey;
            end
            S_DST2: begin
                mul_ctl = MUL_SUB;
                mul_a   = $signed({{(MUL_W-RAD_W-1-FRAC_BITS){1'b0}}, r_reach,
                                   {FRAC_BITS{1'b0}}});
                mul_b   = mul_a;
            end
            S_VS0: begin
                mul_ctl = MUL_CLR;
                mul_a   = ext_d(r_vel_x);
                mul_b   = sx;
            end
            S_VS1: begin
                mul_ctl = MUL_ADD;
                mul_a   = ext_d(r_vel_y);
                mul_b   = sy;
            end
            default: begin
                mul_ctl = '0;
            end
        endcase
    end

    // multiply-divide command select
    always_comb begin
        div_cmd      = '0;
        div_mult     = '0;
        div_dividend = (r_state == S_VS3) ? {vs_abs[DIV_W-2:0], 1'b0} : acc[DIV_W-1:0];
        case (r_state)
            S_PRJ_X: begin
                div_cmd.start = 1'b1;
                div_mult      = mag_d(dx);
            end
            S_PRJ_Y: begin
                div_cmd.start = 1'b1;
                div_cmd.reuse = 1'b1;
                div_mult      = mag_d(dy);
            end
            S_VS3: begin
                div_cmd.start = 1'b1;
                div_cmd.pre   = 1'b1;
                div_mult      = mag_d(sx);
            end
            S_RFL_Y: begin
                div_cmd.start = 1'b1;
                div_cmd.reuse = 1'b1;
                div_mult      = mag_d(sy);
            end
            default: begin
                div_cmd = '0;
            end
        endcase
    end

    csc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_acc   (acc)
    );

    csc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (div_dividend),
        .i_divisor  (r_len2[DIV_W-1:0]),
        .i_mult     (div_mult),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_start_vx <= '0;
            r_start_vy <= '0;
            r_radius   <= RAD_W'(8);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_X:  r_start_x  <= i_cfg.data;
                CFG_START_Y:  r_start_y  <= i_cfg.data;
                CFG_START_VX: r_start_vx <= i_cfg.data;
                CFG_START_VY: r_start_vy <= i_cfg.data;
                CFG_RADIUS:   r_radius   <= i_cfg.data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req    <= i_req.req_type;
                        r_ts     <= i_req.timestep;
                        r_ax     <= i_req.seg_a_x;
                        r_ay     <= i_req.seg_a_y;
                        r_bx     <= i_req.seg_b_x;
                        r_by     <= i_req.seg_b_y;
                        r_reach  <= {1'b0, r_radius} + {1'b0, i_req.pad_pixels};
                        r_box_x  <= i_req.box_centre_x;
                        r_box_y  <= i_req.box_centre_y;
                        r_hit    <= 1'b0;
                        case (i_req.req_type)
                            REQ_LOAD: begin
                                r_pos_x <= r_start_x;
                                r_pos_y <= r_start_y;
                                r_vel_x <= r_start_vx;
                                r_vel_y <= r_start_vy;
                                r_state <= S_DONE;
                            end
                            REQ_TICK: r_state <= S_TICK0;
                            REQ_TEST: r_state <= S_LEN0;
                            default:  r_state <= i_req.check_direction ? S_DIR0 : S_LEN0;
                        endcase
                    end
                end
                S_TICK0: r_state <= S_TICK1;
                S_TICK1: r_state <= S_TICK2;
                S_TICK2: begin
                    r_pos_x <= sat_coord(tick_x_sum);
                    r_state <= S_TICK3;
                end
                S_TICK3: begin
                    r_pos_y <= sat_coord(tick_y_sum);
                    r_state <= S_DONE;
                end
                S_DIR0: r_state <= S_DIR1;
                S_DIR1: r_state <= S_DIR2;
                S_DIR2: r_state <= S_DIR3;
                S_DIR3: r_state <= (acc > 0) ? S_LEN0 : S_DONE;
                S_LEN0: r_state <= S_LEN1;
                S_LEN1: r_state <= S_DOT0;
                S_DOT0: r_state <= S_DOT1;
                S_DOT1: begin
                    r_len2  <= acc;
                    r_state <= S_DOT2;
                end
                S_DOT2: r_state <= S_DOT3;
                S_DOT3: begin
                    // nearest point defaults to end B
                    r_near_x <= r_bx;
                    r_near_y <= r_by;
                    if (r_req == REQ_REFLECT && r_len2 == '0) begin
                        r_state <= S_DONE;
                    end else if (r_len2 != '0 && acc > 0) begin
                        if (acc >= r_len2) begin
                            r_near_x <= r_ax;
                            r_near_y <= r_ay;
                            r_state  <= S_DST0;
                        end else begin
                            r_state <= S_PRJ_X;
                        end
                    end else begin
                        r_state <= S_DST0;
                    end
                end
                S_PRJ_X: r_state <= S_PRJ_XW;
                S_PRJ_XW: begin
                    if (div_done) begin
                        r_near_x <= near_x_sum[COORD_W-1:0];
                        r_state  <= S_PRJ_Y;
                    end
                end
                S_PRJ_Y: r_state <= S_PRJ_YW;
                S_PRJ_YW: begin
                    if (div_done) begin
                        r_near_y <= near_y_sum[COORD_W-1:0];
                        r_state  <= S_DST0;
                    end
                end
                S_DST0: r_state <= S_DST1;
                S_DST1: r_state <= S_DST2;
                S_DST2: r_state <= S_DST3;
                S_DST3: r_state <= S_DST4;
                S_DST4: begin
                    if (r_req == REQ_TEST) begin
                        r_hit   <= (acc <= 0);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= (acc <= 0) ? S_VS0 : S_DONE;
                    end
                end
                S_VS0: r_state <= S_VS1;
                S_VS1: r_state <= S_VS2;
                S_VS2: r_state <= S_VS3;
                S_VS3: begin
                    r_vs_neg <= acc[ACC_W-1];
                    r_state  <= S_RFL_XW;
                end
                S_RFL_XW: begin
                    if (div_done) begin
                        r_vel_x <= sat_coord(rfl_x_sum);
                        r_state <= S_RFL_Y;
                    end
                end
                S_RFL_Y: r_state <= S_RFL_YW;
                S_RFL_YW: begin
                    if (div_done) begin
                        r_vel_y <= sat_coord(rfl_y_sum);
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_pos_x <= r_pos_x;
                        r_out_pos_y <= r_pos_y;
                        r_out_vel_x <= r_vel_x;
                        r_out_vel_y <= r_vel_y;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.collided = r_out_hit;
    assign o_rsp.pos_x    = r_out_pos_x;
    assign o_rsp.pos_y    = r_out_pos_y;
    assign o_rsp.vel_x    = r_out_vel_x;
    assign o_rsp.vel_y    = r_out_vel_y;

    `CSC_ASSERT_NOW(a_div_done_waited, i_clk, i_rst_n, div_done, (r_state == S_PRJ_XW || r_state == S_PRJ_YW || r_state == S_RFL_XW || r_state == S_RFL_YW))
    `CSC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `CSC_ASSERT_NEXT(a_load_copies_start, i_clk, i_rst_n, i_req.valid && i_req.ready && i_req.req_type == REQ_LOAD, r_pos_x == $past(r_start_x) && r_vel_y == $past(r_start_vy))

endmodule

FILE: tb/circle_segment_collide_reflect_core_tb.sv
`timescale 1ns / 1ps

module circle_segment_collide_reflect_core_tb;
    import csc_pkg::*;

    typedef struct {
        logic [REQ_W-1:0] req_type;
        logic [TS_W-1:0]  timestep;
        t_coord           ax, ay, bx, by;
        logic [RAD_W-1:0] pad;
        logic             chk;
        t_coord           cx, cy;
    } t_req;

    typedef struct {
        logic   collided;
        t_coord pos_x, pos_y, vel_x, vel_y;
    } t_state_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csc_cfg_if cfg_ch ();
    csc_in_if  req_ch ();
    csc_out_if rsp_ch ();

    circle_segment_collide_reflect_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    longint st_x, st_y, st_vx, st_vy, rad;
    longint p_x, p_y, v_x, v_y;
    t_state_word expected_words[$];

    int mismatches = 0;
    int words_checked = 0;
    int hits_seen = 0;
    int cycle_count = 0;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int hold_cycles = 0;

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint move_delta(longint ts, longint v);
        longint p;
        p = ts * v;
        return p >>> TICK_FRAC;
    endfunction

    // floor(a*b/c) without overflow of the 64-bit product
    function automatic longint unsigned frac_scale(longint unsigned a, longint unsigned b,
                                                   longint unsigned c);
        longint unsigned q0, r0, q, r;
        q0 = a / c;
        r0 = a % c;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            q = q << 1;
            r = r << 1;
            if (r >= c) begin
                r -= c;
                q++;
            end
            if (b[i]) begin
                r += r0;
                if (r >= c) begin
                    r -= c;
                    q++;
                end
            end
        end
        return q0 * b + q;
    endfunction

    function automatic longint signed_scale(longint unsigned a, bit neg, longint s,
                                            longint unsigned c);
        longint unsigned m;
        m = frac_scale(a, (s < 0) ? -s : s, c);
        return (neg != (s < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit circle_touches(longint ax, longint ay, longint bx, longint by,
                                          longint reach);
        longint dx, dy, wx, wy, len2, dotp, nx, ny, ex, ey;
        longint unsigned dist2, r;
        dx = ax - bx;
        dy = ay - by;
        wx = p_x - bx;
        wy = p_y - by;
        len2 = dx * dx + dy * dy;
        dotp = wx * dx + wy * dy;
        nx = bx;
        ny = by;
        if (len2 != 0 && dotp > 0) begin
            if (dotp >= len2) begin
                nx = ax;
                ny = ay;
            end else begin
                nx = bx + signed_scale(dotp, 1'b0, dx, len2);
                ny = by + signed_scale(dotp, 1'b0, dy, len2);
            end
        end
        ex = p_x - nx;
        ey = p_y - ny;
        dist2 = longint'(ex * ex) + longint'(ey * ey);
        r = reach << FRAC_BITS;
        return dist2 <= r * r;
    endfunction

    function automatic void predict_motion(t_req q);
        t_state_word w;
        longint ax, ay, bx, by, sx, sy, len2, t, vs;
        longint unsigned u;
        bit go, hit;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
        hit = 1'b0;
        case (q.req_type)
            REQ_LOAD: begin
                p_x = st_x; p_y = st_y; v_x = st_vx; v_y = st_vy;
            end
            REQ_TICK: begin
                p_x = sat24(p_x + move_delta(q.timestep, v_x));
                p_y = sat24(p_y + move_delta(q.timestep, v_y));
            end
            REQ_TEST: hit = circle_touches(ax, ay, bx, by, rad + q.pad);
            default: begin
                go = 1'b1;
                sx = bx - ax;
                sy = by - ay;
                len2 = sx * sx + sy * sy;
                if (q.chk) begin
                    t = (longint'(q.cx) - p_x) * v_x + (longint'(q.cy) - p_y) * v_y;
                    go = t > 0;
                end
                if (go && len2 != 0 && circle_touches(ax, ay, bx, by, rad + q.pad)) begin
                    vs = v_x * sx + v_y * sy;
                    u = ((vs < 0) ? -vs : vs) * 2;
                    t = sat24(signed_scale(u, vs < 0, sx, len2) - v_x);
                    v_y = sat24(signed_scale(u, vs < 0, sy, len2) - v_y);
                    v_x = t;
                    hit = 1'b1;
                end
            end
        endcase
        w.collided = hit;
        w.pos_x = p_x[23:0];
        w.pos_y = p_y[23:0];
        w.vel_x = v_x[23:0];
        w.vel_y = v_y[23:0];
        expected_words.push_back(w);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("circle_segment_collide_reflect_core test failed");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_state_word e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                e = expected_words.pop_front();
                words_checked++;
                if (rsp_ch.collided) hits_seen++;
                if (rsp_ch.collided !== e.collided || rsp_ch.pos_x !== e.pos_x ||
                    rsp_ch.pos_y !== e.pos_y || rsp_ch.vel_x !== e.vel_x ||
                    rsp_ch.vel_y !== e.vel_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp c=%0b p=(%0d,%0d) v=(%0d,%0d)",
                            e.collided, e.pos_x, e.pos_y, e.vel_x, e.vel_y,
                            " got c=%0b p=(%0d,%0d) v=(%0d,%0d)",
                            rsp_ch.collided, rsp_ch.pos_x, rsp_ch.pos_y,
                            rsp_ch.vel_x, rsp_ch.vel_y);
                end
            end
        end
    end

    // receiver ready, with random stalls and a long hold-off on request
    initial begin
        int gap;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 4);
                rsp_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[23:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_START_X:  st_x = t_coord'(value[23:0]);
            CFG_START_Y:  st_y = t_coord'(value[23:0]);
            CFG_START_VX: st_vx = t_coord'(value[23:0]);
            CFG_START_VY: st_vy = t_coord'(value[23:0]);
            CFG_RADIUS:   rad = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_request(t_req q);
        if (send_idle_en && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= q.req_type;
        req_ch.timestep        <= q.timestep;
        req_ch.seg_a_x         <= q.ax;
        req_ch.seg_a_y         <= q.ay;
        req_ch.seg_b_x         <= q.bx;
        req_ch.seg_b_y         <= q.by;
        req_ch.pad_pixels      <= q.pad;
        req_ch.check_direction <= q.chk;
        req_ch.box_centre_x    <= q.cx;
        req_ch.box_centre_y    <= q.cy;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_motion(q);
        // the core drops ready once it has taken a word
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic t_coord rnd_coord();
        return t_coord'($urandom());
    endfunction

    // coordinate near the ball so contact is likely
    function automatic t_coord near(longint c, int spread);
        return t_coord'(sat24(c + $signed($urandom_range(0, 2 * spread)) - spread));
    endfunction

    function automatic t_req blank_req(logic [REQ_W-1:0] kind);
        t_req q;
        q.req_type = kind;
        q.timestep = TS_W'($urandom());
        q.ax = rnd_coord(); q.ay = rnd_coord();
        q.bx = rnd_coord(); q.by = rnd_coord();
        q.pad = RAD_W'($urandom());
        q.chk = 1'($urandom());
        q.cx = rnd_coord(); q.cy = rnd_coord();
        return q;
    endfunction

    function automatic t_req local_req(logic [REQ_W-1:0] kind);
        t_req q;
        int spread;
        q = blank_req(kind);
        spread = 1 << $urandom_range(8, 14);
        q.ax = near(p_x, spread); q.ay = near(p_y, spread);
        q.bx = near(p_x, spread); q.by = near(p_y, spread);
        q.pad = RAD_W'($urandom_range(0, 15));
        q.cx = near(p_x, spread); q.cy = near(p_y, spread);
        q.timestep = TS_W'($urandom_range(0, 1024));
        return q;
    endfunction

    task automatic test_directed();
        t_req q;
        write_reg(CFG_START_X, 24'sh000100);
        write_reg(CFG_START_Y, -24'sd512);
        write_reg(CFG_START_VX, 24'sd256);
        write_reg(CFG_START_VY, -24'sd128);
        write_reg(CFG_RADIUS, 8);
        send_request(blank_req(REQ_LOAD));
        q = blank_req(REQ_TICK); q.timestep = 16'h0000; send_request(q);
        q.timestep = 16'hFFFF; send_request(q);
        q.timestep = 16'h0100; send_request(q);
        // segment crossing the ball, then zero-length segment on the ball
        q = local_req(REQ_TEST); q.ax = t_coord'(p_x - 4096); q.ay = t_coord'(p_y);
        q.bx = t_coord'(p_x + 4096); q.by = t_coord'(p_y + 256); send_request(q);
        q.ax = t_coord'(p_x); q.ay = t_coord'(p_y); q.bx = t_coord'(p_x);
        q.by = t_coord'(p_y); send_request(q);
        q.req_type = REQ_REFLECT; send_request(q);
        q = local_req(REQ_REFLECT); q.ax = t_coord'(p_x - 4096); q.ay = t_coord'(p_y + 300);
        q.bx = t_coord'(p_x + 4096); q.by = t_coord'(p_y + 300); q.chk = 1'b0;
        send_request(q);
        q.chk = 1'b1; q.cx = t_coord'(p_x + v_x * 4); q.cy = t_coord'(p_y + v_y * 4);
        send_request(q);
        q.cx = t_coord'(p_x - v_x * 4); q.cy = t_coord'(p_y - v_y * 4); send_request(q);
        // nearest point at each end
        q = local_req(REQ_TEST); q.ax = t_coord'(p_x + 512); q.ay = t_coord'(p_y);
        q.bx = t_coord'(p_x + 9000); q.by = t_coord'(p_y); send_request(q);
        q.ax = t_coord'(p_x + 9000); q.bx = t_coord'(p_x + 512); send_request(q);
        // extreme coordinates and pads
        q = blank_req(REQ_TEST); q.ax = 24'sh7FFFFF; q.ay = 24'sh800000;
        q.bx = 24'sh800000; q.by = 24'sh7FFFFF; q.pad = 8'hFF; send_request(q);
        q.req_type = REQ_REFLECT; q.chk = 1'b0; send_request(q);
        drain_results();
        // zero velocity never passes the direction check
        write_reg(CFG_START_X, 24'sh7FFFFF);
        write_reg(CFG_START_Y, 24'sh800000);
        write_reg(CFG_START_VX, 0);
        write_reg(CFG_START_VY, 0);
        write_reg(CFG_RADIUS, 255);
        send_request(blank_req(REQ_LOAD));
        q = local_req(REQ_REFLECT); q.chk = 1'b1; send_request(q);
        q = blank_req(REQ_TICK); q.timestep = 16'hFFFF; send_request(q);
        drain_results();
        write_reg(CFG_START_X, 24'sh7FFF00);
        write_reg(CFG_START_Y, 24'sh800100);
        write_reg(CFG_START_VX, 24'sh7FFFFF);
        write_reg(CFG_START_VY, 24'sh800000);
        write_reg(CFG_RADIUS, 0);
        send_request(blank_req(REQ_LOAD));
        q = blank_req(REQ_TICK); q.timestep = 16'hFFFF; send_request(q);
        q = local_req(REQ_REFLECT); q.chk = 1'b0; q.ax = t_coord'(p_x - 2048);
        q.ay = t_coord'(p_y); q.bx = t_coord'(p_x + 2048); q.by = t_coord'(p_y);
        q.pad = 8'hFF; send_request(q);
        drain_results();
    endtask

    task automatic test_random_phase(int count);
        t_req q;
        int pick;
        write_reg(CFG_START_X, $signed($urandom_range(0, 1 << 20)) - (1 << 19));
        write_reg(CFG_START_Y, $signed($urandom_range(0, 1 << 20)) - (1 << 19));
        write_reg(CFG_START_VX, $signed($urandom_range(0, 8192)) - 4096);
        write_reg(CFG_START_VY, $signed($urandom_range(0, 8192)) - 4096);
        write_reg(CFG_RADIUS, $urandom_range(0, 40));
        send_request(blank_req(REQ_LOAD));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) q = blank_req(REQ_LOAD);
            else if (pick < 30) q = local_req(REQ_TICK);
            else if (pick < 55) q = local_req(REQ_TEST);
            else if (pick < 90) q = local_req(REQ_REFLECT);
            else q = blank_req(2'($urandom_range(0, 3)));
            send_request(q);
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        for (int i = 0; i < 12; i++) send_request(local_req(REQ_TICK));
        drain_results();
    endtask

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.timestep = '0;
        req_ch.seg_a_x = '0; req_ch.seg_a_y = '0;
        req_ch.seg_b_x = '0; req_ch.seg_b_y = '0;
        req_ch.pad_pixels = '0;
        req_ch.check_direction = 1'b0;
        req_ch.box_centre_x = '0; req_ch.box_centre_y = '0;
        st_x = 0; st_y = 0; st_vx = 0; st_vy = 0; rad = 8;
        p_x = 0; p_y = 0; v_x = 0; v_y = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        for (int ph = 0; ph < 6; ph++) test_random_phase(220);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random_phase(250);
        $display("checked %0d result words, %0d with contact, over loads, ticks, tests",
                 words_checked, hits_seen);
        $display("and reflections across several start and radius settings");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("circle_segment_collide_reflect_core test passed");
        end else begin
            $display("circle_segment_collide_reflect_core test failed");
        end
        $finish;
    end

endmodule
